/* design/bcc_pkg.sv */
package bcc_pkg;

  // width of every input field
  localparam int FIELD_W = 10;

  // query classes decided at the front
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_RUN       = 2'd0;
  localparam kind_t KIND_ZERO_ROWS = 2'd1;
  localparam kind_t KIND_OVER      = 2'd2;

  // one classified query as held in the queue
  typedef struct packed {
    kind_t              kind;
    logic [FIELD_W-1:0] part_count;
    logic [FIELD_W-1:0] target_total;
    logic [FIELD_W-1:0] min_part;
  } job_t;

endpackage

/* design/bcc_ram.sv */
module bcc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/bcc_front.sv */
module bcc_front #(
  parameter int MAX_TOTAL = 1023
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bcc_pkg::FIELD_W-1:0] in_part_count,
  input  logic [bcc_pkg::FIELD_W-1:0] in_target_total,
  input  logic [bcc_pkg::FIELD_W-1:0] in_min_part,
  output logic                        q_valid,
  output bcc_pkg::job_t               q_job,
  input  logic                        q_pop
);

  bcc_pkg::job_t ent_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  bcc_pkg::job_t new_job;
  logic          push;

  // classify the incoming word
  always_comb begin
    new_job.part_count   = in_part_count;
    new_job.target_total = in_target_total;
    new_job.min_part     = in_min_part;
    if (int'(in_target_total) > MAX_TOTAL) begin
      new_job.kind = bcc_pkg::KIND_OVER;
    end else if (in_part_count == '0) begin
      new_job.kind = bcc_pkg::KIND_ZERO_ROWS;
    end else begin
      new_job.kind = bcc_pkg::KIND_RUN;
    end
  end

  // two-entry queue towards the engine
  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_job    = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= new_job;
    end
  end

endmodule

/* design/bcc_back.sv */
module bcc_back #(
  parameter int MAX_TOTAL   = 1023,
  parameter int COUNT_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  bcc_pkg::job_t q_job,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   out_ways,
  output logic          out_saturated
);

  localparam int Depth = MAX_TOTAL + 1;
  localparam int AddrW = $clog2(Depth);
  localparam int FW    = bcc_pkg::FIELD_W;
  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_GAP  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]             state_r, state_nxt;
  bcc_pkg::job_t          job_r, job_nxt;
  logic [FW-1:0]          row_r, row_nxt;
  logic [FW-1:0]          idx_r, idx_nxt;
  logic                   bank_r, bank_nxt;
  logic [COUNT_WIDTH-1:0] acc_r, acc_nxt;
  logic                   flag_r, flag_nxt;
  logic [COUNT_WIDTH-1:0] res_r, res_nxt;

  logic          wr_v_r, wr_v_nxt;
  logic [FW-1:0] wr_idx_r, wr_idx_nxt;
  logic          wr_bank_r, wr_bank_nxt;
  logic          wr_zero_r, wr_zero_nxt;
  logic          wr_first_r, wr_first_nxt;
  logic          wr_one_r, wr_one_nxt;
  logic          wr_endrow_r, wr_endrow_nxt;
  logic          wr_last_r, wr_last_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_ways_r, out_ways_nxt;
  logic          out_sat_r, out_sat_nxt;

  logic [AddrW-1:0]       raddr, waddr;
  logic [COUNT_WIDTH-1:0] rdata0, rdata1, rdata, addend, val;
  logic [COUNT_WIDTH:0]   sum;
  logic                   we0, we1;
  logic                   iss_end, last_row;

  // ping-pong row stores: read one bank, build the other
  assign raddr = AddrW'(idx_r - job_r.min_part);
  assign waddr = AddrW'(wr_idx_r);
  assign we0   = wr_v_r && !wr_bank_r;
  assign we1   = wr_v_r && wr_bank_r;

  bcc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(Depth)) u_row0 (
    .clk(clk), .we(we0), .waddr(waddr), .wdata(val), .raddr(raddr), .rdata(rdata0)
  );

  bcc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(Depth)) u_row1 (
    .clk(clk), .we(we1), .waddr(waddr), .wdata(val), .raddr(raddr), .rdata(rdata1)
  );

  // accumulate stage: running prefix sum with saturation
  assign rdata = wr_bank_r ? rdata0 : rdata1;

  always_comb begin
    if (wr_zero_r) begin
      addend = '0;
    end else if (wr_first_r) begin
      addend = COUNT_WIDTH'(wr_one_r);
    end else begin
      addend = rdata;
    end
    sum = {1'b0, acc_r} + {1'b0, addend};
    val = sum[COUNT_WIDTH] ? CountMax : sum[COUNT_WIDTH-1:0];
  end

  // issue-side conditions
  assign iss_end  = (idx_r == job_r.target_total);
  assign last_row = (row_r == job_r.part_count - FW'(1));

  // sequencer over rows and entries
  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    row_nxt       = row_r;
    idx_nxt       = idx_r;
    bank_nxt      = bank_r;
    acc_nxt       = acc_r;
    flag_nxt      = flag_r;
    res_nxt       = res_r;
    wr_v_nxt      = 1'b0;
    wr_idx_nxt    = idx_r;
    wr_bank_nxt   = ~bank_r;
    wr_zero_nxt   = idx_r < job_r.min_part;
    wr_first_nxt  = (row_r == '0);
    wr_one_nxt    = (idx_r == job_r.min_part);
    wr_endrow_nxt = iss_end;
    wr_last_nxt   = iss_end && last_row;
    out_valid_nxt = out_valid_r;
    out_ways_nxt  = out_ways_r;
    out_sat_nxt   = out_sat_r;
    q_pop         = 1'b0;

    if (wr_v_r) begin
      acc_nxt = wr_endrow_r ? '0 : val;
      if (sum[COUNT_WIDTH]) begin
        flag_nxt = 1'b1;
      end
      if (wr_last_r) begin
        res_nxt = val;
      end
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          job_nxt  = q_job;
          row_nxt  = '0;
          idx_nxt  = '0;
          bank_nxt = 1'b0;
          acc_nxt  = '0;
          flag_nxt = 1'b0;
          if (q_job.kind == bcc_pkg::KIND_RUN) begin
            state_nxt = S_RUN;
          end else begin
            res_nxt   = COUNT_WIDTH'(q_job.kind == bcc_pkg::KIND_ZERO_ROWS &&
                                     q_job.target_total == '0);
            state_nxt = S_OUT;
          end
        end
      end
      S_RUN: begin
        wr_v_nxt = 1'b1;
        if (iss_end) begin
          row_nxt   = row_r + FW'(1);
          state_nxt = S_GAP;
        end else begin
          idx_nxt = idx_r + FW'(1);
        end
      end
      S_GAP: begin
        idx_nxt   = '0;
        bank_nxt  = ~bank_r;
        state_nxt = (row_r == job_r.part_count) ? S_OUT : S_RUN;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_ways_nxt  = 32'(res_r);
          out_sat_nxt   = flag_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wr_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_v_r      <= wr_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    job_r       <= job_nxt;
    row_r       <= row_nxt;
    idx_r       <= idx_nxt;
    bank_r      <= bank_nxt;
    acc_r       <= acc_nxt;
    flag_r      <= flag_nxt;
    res_r       <= res_nxt;
    wr_idx_r    <= wr_idx_nxt;
    wr_bank_r   <= wr_bank_nxt;
    wr_zero_r   <= wr_zero_nxt;
    wr_first_r  <= wr_first_nxt;
    wr_one_r    <= wr_one_nxt;
    wr_endrow_r <= wr_endrow_nxt;
    wr_last_r   <= wr_last_nxt;
    out_ways_r  <= out_ways_nxt;
    out_sat_r   <= out_sat_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_ways      = out_ways_r;
  assign out_saturated = out_sat_r;

  // checks
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == S_IDLE && q_valid))
    else $error("queue popped outside idle");

  a_stage_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_v_r |-> (wr_idx_r <= job_r.target_total))
    else $error("row write beyond target total");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (row_r < job_r.part_count))
    else $error("row pass beyond part count");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && (!out_valid_r || out_ready)) |=> out_valid_r)
    else $error("result not loaded into output register");

endmodule

/* design/bounded_composition_count.sv */
// Counts ordered compositions of in_target_total into in_part_count parts,
// each part at least in_min_part. One result word per query word.
// Input channel in_valid/in_ready carries the three query fields; result
// channel out_valid/out_ready carries out_ways and out_saturated, which is
// set when any addition of the query clamped at the largest count value.
// A two-word queue sits after the input, so up to two queries are taken
// while the engine works and a finished result waits in the output register.
// A query with zero parts or a total above MAX_TOTAL goes straight to the
// output register; any other query runs through the row engine, which does
// one entry per cycle within a row over two row RAMs (one write and one read
// port each), with a turnaround state between rows.
// Queries are served one at a time in arrival order; the engine takes the
// next query only once the result of the last one is in the output register.
// Reset (rst_n low, synchronous) empties the queue and the output register;
// the row RAMs need no clearing, each query writes what it later reads.
// When the receiver stalls, the result holds on out_* and the engine waits
// with the next result until the output register is free.
module bounded_composition_count #(
  parameter int MAX_TOTAL   = 1023,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bcc_pkg::FIELD_W-1:0] in_part_count,
  input  logic [bcc_pkg::FIELD_W-1:0] in_target_total,
  input  logic [bcc_pkg::FIELD_W-1:0] in_min_part,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [31:0]                 out_ways,
  output logic                        out_saturated
);

  logic          q_valid;
  logic          q_pop;
  bcc_pkg::job_t q_job;

  // input side: classify and queue
  bcc_front #(.MAX_TOTAL(MAX_TOTAL)) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_part_count(in_part_count),
    .in_target_total(in_target_total),
    .in_min_part(in_min_part),
    .q_valid(q_valid),
    .q_job(q_job),
    .q_pop(q_pop)
  );

  // row engine and result register
  bcc_back #(.MAX_TOTAL(MAX_TOTAL), .COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .q_valid(q_valid),
    .q_job(q_job),
    .q_pop(q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_ways(out_ways),
    .out_saturated(out_saturated)
  );

endmodule
